// ===== rtl/core/pwlct_pkg.sv =====
package pwlct_pkg;

   // Field widths
   localparam int OP_W       = 2;
   localparam int POS_W      = 17;
   localparam int VAL_W      = 32;
   localparam int STATUS_W   = 2;

   // Stream payload widths: position and node value, padded to whole bytes
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   // Default table depth
   localparam int MAX_NODES_DEFAULT = 32;

   // Product of a 33-bit value span and a 16-bit position offset
   localparam int PROD_W    = 49;
   // Quotient bits produced by the divider: the quotient never exceeds the value span
   localparam int DIV_STEPS = 33;
   localparam int ITER_W    = $clog2(DIV_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_INVALID  = 2'd1,
      STS_CAPACITY = 2'd2,
      STS_ORDER    = 2'd3
   } status_type;

endpackage

// ===== rtl/core/piecewise_linear_curve_table.sv =====
// Clear, add and every rejected request answer one cycle after acceptance.
// A query scans the node memory one entry per cycle; a position at or below the first node
// or past the last answers as soon as the scan ends. Between nodes it adds a multiply step,
// a sign step, a restoring divide and an add step; one request is in flight at a time.
// Synchronous reset empties the table; the node memories are not cleared.
module piecewise_linear_curve_table #(
   parameter int MAX_NODES = pwlct_pkg::MAX_NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [16:0] position, [48:17] node_value, [55:49] zero
   input  logic [pwlct_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] opcode
   input  logic [pwlct_pkg::OP_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] result_value
   output logic [pwlct_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [pwlct_pkg::STATUS_W-1:0]    rsp_tuser
);
   import pwlct_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Node memories
   logic signed [POS_W-1:0] pos_mem [MAX_NODES];
   logic        [VAL_W-1:0] val_mem [MAX_NODES];

   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic signed [POS_W-1:0] rd_pos_ff;
   logic        [VAL_W-1:0] rd_val_ff;
   logic                    wr_en;

   // Control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     scan_idx_ff, scan_idx_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic signed [POS_W-1:0]  last_pos_ff, last_pos_in;
   logic signed [POS_W-1:0]  t_ff, t_in;
   logic signed [POS_W-1:0]  prev_pos_ff, prev_pos_in;
   logic        [VAL_W-1:0]  prev_val_ff, prev_val_in;
   logic        [VAL_W-1:0]  base_ff, base_in;
   logic signed [VAL_W:0]    diff_ff, diff_in;
   logic        [15:0]       dt_ff, dt_in;
   logic        [15:0]       dx_ff, dx_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic        [15:0]       rem_ff, rem_in;
   logic [DIV_STEPS-1:0]     quot_ff, quot_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic        [VAL_W-1:0]  rsp_value_ff, rsp_value_in;

   // Request fields
   opcode_type              req_op;
   logic signed [POS_W-1:0] req_pos;
   logic        [VAL_W-1:0] req_val;
   logic                    req_fire;

   // Arithmetic intermediates
   logic signed [PROD_W:0]   mult;
   logic        [PROD_W-1:0] prod_mag;
   logic        [16:0]       div_trial;
   logic        [16:0]       div_sub;
   logic signed [VAL_W+1:0]  quot_signed;
   logic signed [VAL_W+1:0]  final_sum;
   logic        [POS_W-1:0]  span_t;
   logic        [POS_W-1:0]  span_x;

   assign req_op   = opcode_type'(req_tuser);
   assign req_pos  = req_tdata[POS_W-1:0];
   assign req_val  = req_tdata[POS_W+VAL_W-1:POS_W];

   // Take a request only when idle and the result slot is free or draining
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign wr_en = req_fire && (req_op == OP_ADD) && (rsp_status_in == STS_OK);

   assign mult        = diff_ff * $signed({1'b0, dt_ff});
   assign prod_mag    = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : prod_ff;
   assign div_trial   = {rem_ff, quot_ff[DIV_STEPS-1]};
   assign div_sub     = div_trial - {1'b0, dx_ff};
   assign quot_signed = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
   assign final_sum   = $signed({{2{base_ff[VAL_W-1]}}, base_ff}) + quot_signed;
   assign span_t      = t_ff - prev_pos_ff;
   assign span_x      = rd_pos_ff - prev_pos_ff;

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      iter_in       = iter_ff;
      rsp_valid_in  = rsp_valid_ff;
      last_pos_in   = last_pos_ff;
      t_in          = t_ff;
      prev_pos_in   = prev_pos_ff;
      prev_val_in   = prev_val_ff;
      base_in       = base_ff;
      diff_in       = diff_ff;
      dt_in         = dt_ff;
      dx_in         = dx_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_idx_ff;

      // Drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_value_in  = '0;
               unique case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_ADD: begin
                     priority if (req_pos[POS_W-1]) begin
                        rsp_status_in = STS_INVALID;
                     end else if (count_ff == CW'(MAX_NODES)) begin
                        rsp_status_in = STS_CAPACITY;
                     end else if ((count_ff != '0) && (req_pos <= last_pos_ff)) begin
                        rsp_status_in = STS_ORDER;
                     end else begin
                        count_in    = count_ff + 1'b1;
                        last_pos_in = req_pos;
                     end
                  end
                  OP_QUERY: begin
                     if ((count_ff == '0) || req_pos[POS_W-1]) begin
                        rsp_status_in = STS_INVALID;
                     end else begin
                        // Hold the result until the scan resolves
                        rsp_valid_in = 1'b0;
                        t_in         = req_pos;
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        scan_idx_in  = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_INVALID;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            priority if (t_ff <= rd_pos_ff) begin
               if (scan_idx_ff == '0) begin
                  // At or below the first node
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STS_OK;
                  rsp_value_in  = rd_val_ff;
                  state_in      = ST_IDLE;
               end else begin
                  base_in  = prev_val_ff;
                  diff_in  = $signed({rd_val_ff[VAL_W-1], rd_val_ff})
                           - $signed({prev_val_ff[VAL_W-1], prev_val_ff});
                  dt_in    = span_t[15:0];
                  dx_in    = span_x[15:0];
                  state_in = ST_MUL;
               end
            end else if (CW'(scan_idx_ff) == CW'(count_ff - 1'b1)) begin
               // Above the last node
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_value_in  = rd_val_ff;
               state_in      = ST_IDLE;
            end else begin
               // Advance to the next node
               prev_pos_in = rd_pos_ff;
               prev_val_in = rd_val_ff;
               rd_en       = 1'b1;
               rd_addr     = AW'(scan_idx_ff + 1'b1);
               scan_idx_in = AW'(scan_idx_ff + 1'b1);
            end
         end

         ST_MUL: begin
            prod_in  = mult[PROD_W-1:0];
            state_in = ST_PREP;
         end

         ST_PREP: begin
            // Split into sign and magnitude; the top bits stay below the divisor
            neg_in   = prod_ff[PROD_W-1];
            rem_in   = {1'b0, prod_mag[PROD_W-2:DIV_STEPS]};
            quot_in  = prod_mag[DIV_STEPS-1:0];
            iter_in  = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // Restoring division, one quotient bit per cycle
            if (div_trial >= {1'b0, dx_ff}) begin
               rem_in  = div_sub[15:0];
               quot_in = {quot_ff[DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in  = div_trial[15:0];
               quot_in = {quot_ff[DIV_STEPS-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_OK;
            rsp_value_in  = final_sum[VAL_W-1:0];
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_pos_ff   <= last_pos_in;
      t_ff          <= t_in;
      prev_pos_ff   <= prev_pos_in;
      prev_val_ff   <= prev_val_in;
      base_ff       <= base_in;
      diff_ff       <= diff_in;
      dt_ff         <= dt_in;
      dx_ff         <= dx_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Node memories: an add writes and a later query reads, so no access overlaps
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[count_ff[AW-1:0]] <= req_pos;
         val_mem[count_ff[AW-1:0]] <= req_val;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_pos_ff <= pos_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
      end
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pwlct_pkg::*;

   localparam int          TABLE_DEPTH = MAX_NODES_DEFAULT;
   localparam int          DRAIN_CYCLES = TABLE_DEPTH + 40;
   localparam int          PHASE_ITEMS = 475;
   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam int          POS_MAX = 65535;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [POS_W-1:0]  position;
      logic signed [VAL_W-1:0]  node_value;
   } request_type;

   typedef struct {
      status_type               status;
      logic signed [VAL_W-1:0]  value;
   } answer_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [OP_W-1:0]         req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;

   // Shadow copy of the breakpoint table
   logic signed [POS_W-1:0] knot_pos [TABLE_DEPTH];
   logic signed [VAL_W-1:0] knot_val [TABLE_DEPTH];
   int                      knot_count = 0;

   request_type             request_backlog [$];
   answer_type              expected_answers [$];
   request_type             offered;
   int                      queued_items = 0;
   int                      mismatch_count = 0;
   int                      sender_idle_pct = 0;
   int                      receiver_stall_pct = 0;

   piecewise_linear_curve_table #(
      .MAX_NODES (TABLE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Interpolate the shadow table at a non-negative position
   function automatic logic signed [VAL_W-1:0] curve_at(input logic signed [POS_W-1:0] t);
      longint x0, x1, v0, v1;
      int     k;
      if (t <= knot_pos[0]) return knot_val[0];
      for (k = 1; k < knot_count; k++) begin
         if (t <= knot_pos[k]) begin
            x0 = knot_pos[k-1];
            x1 = knot_pos[k];
            v0 = knot_val[k-1];
            v1 = knot_val[k];
            // longint division truncates toward zero, like the block's divider
            return 32'(v0 + ((v1 - v0) * (longint'(t) - x0)) / (x1 - x0));
         end
      end
      return knot_val[knot_count-1];
   endfunction

   // Apply one request to the shadow table and return the answer it produces
   function automatic answer_type curve_table_apply(input request_type rq);
      answer_type ans;
      ans.status = STS_OK;
      ans.value  = '0;
      case (rq.op)
         OP_CLEAR: knot_count = 0;
         OP_ADD: begin
            if (rq.position < 0)
               ans.status = STS_INVALID;
            else if (knot_count >= TABLE_DEPTH)
               ans.status = STS_CAPACITY;
            else if (knot_count > 0 && rq.position <= knot_pos[knot_count-1])
               ans.status = STS_ORDER;
            else begin
               knot_pos[knot_count] = rq.position;
               knot_val[knot_count] = rq.node_value;
               knot_count++;
            end
         end
         OP_QUERY: begin
            if (knot_count == 0 || rq.position < 0)
               ans.status = STS_INVALID;
            else
               ans.value = curve_at(rq.position);
         end
         default: ans.status = STS_INVALID;
      endcase
      return ans;
   endfunction

   // Request driver: predict on each accepted transaction, then offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_answers.push_back(curve_table_apply(offered));
         end
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, offered.node_value, offered.position};
               req_tuser  <= offered.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted transaction against the oldest answer
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, actual status %0d value %0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tuser !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
               end
               if (rsp_tdata !== want.value) begin
                  mismatch_count++;
                  $display("%0t: value mismatch, expected %0h, actual %0h",
                           $time, want.value, rsp_tdata);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic enqueue(input logic [OP_W-1:0] op, input int pos, input logic [VAL_W-1:0] val);
      request_type rq;
      rq.op         = op;
      rq.position   = pos[POS_W-1:0];
      rq.node_value = val;
      request_backlog.push_back(rq);
      queued_items++;
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      if ($urandom_range(7) == 0)
         return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return $urandom();
   endfunction

   function automatic int negative_pos();
      return -int'($urandom_range(1, 65536));
   endfunction

   // Hold until every queued request is accepted and every answer has arrived
   task automatic wait_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_tvalid || expected_answers.size() != 0);
   endtask

   // Build a table, sprinkle in rejected adds and unused opcodes, then query it
   task automatic queue_session(input bit fill_up);
      int nodes, start, max_step, pos, last_pos, k;
      int placed [$];
      enqueue(OP_CLEAR, $urandom_range(0, 131071), $urandom());
      if (fill_up || $urandom_range(99) < 12)
         nodes = TABLE_DEPTH + 1 + $urandom_range(0, 1);
      else
         nodes = $urandom_range(1, 12);
      start = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 3000);
      max_step = (POS_MAX - start) / nodes;
      if ($urandom_range(3) == 0 && max_step > 3) max_step = 3;
      if (max_step < 1) max_step = 1;
      last_pos = -1;
      for (k = 0; k < nodes; k++) begin
         if (last_pos >= 0 && $urandom_range(9) == 0) begin
            case ($urandom_range(2))
               0: enqueue(OP_ADD, negative_pos(), $urandom());
               1: enqueue(OP_ADD, $urandom_range(0, last_pos), $urandom());
               default: enqueue(OP_UNUSED, $urandom_range(0, 131071), $urandom());
            endcase
         end
         pos = (last_pos < 0) ? start : last_pos + $urandom_range(1, max_step);
         enqueue(OP_ADD, pos, pick_value());
         placed.push_back(pos);
         last_pos = pos;
      end
      repeat ($urandom_range(2, 10)) begin
         case ($urandom_range(7))
            0: pos = placed[$urandom_range(0, placed.size() - 1)];
            1: pos = $urandom_range(0, placed[0]);
            2: pos = $urandom_range(last_pos, POS_MAX);
            3: pos = negative_pos();
            default: pos = $urandom_range(placed[0], last_pos);
         endcase
         enqueue(OP_QUERY, pos, $urandom());
      end
   endtask

   // Fill the backlog with sessions and some raw noise
   task automatic queue_random(input int count, input bit fill_first);
      int base;
      bit first;
      base  = queued_items;
      first = fill_first;
      while (queued_items - base < count) begin
         if (!first && $urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6))
               enqueue(OP_W'($urandom_range(0, 3)), $urandom_range(0, 131071), $urandom());
         end else begin
            queue_session(first);
            first = 1'b0;
         end
      end
   endtask

   task automatic queue_directed();
      enqueue(OP_QUERY, 5, 32'h0);
      enqueue(OP_UNUSED, 0, 32'h0);
      enqueue(OP_ADD, -1, 32'h1234_5678);
      enqueue(OP_ADD, 0, 32'h8000_0000);
      enqueue(OP_ADD, 0, 32'h0000_0001);
      enqueue(OP_ADD, POS_MAX, 32'h7FFF_FFFF);
      enqueue(OP_QUERY, -1, 32'h0);
      enqueue(OP_QUERY, 0, 32'h0);
      enqueue(OP_QUERY, 32768, 32'hFFFF_FFFF);
      enqueue(OP_QUERY, POS_MAX, 32'h0);
      enqueue(OP_QUERY, -65536, 32'h0);
      enqueue(OP_ADD, POS_MAX, 32'h0);
      enqueue(OP_CLEAR, 0, 32'h0);
      enqueue(OP_QUERY, 5, 32'h0);
      enqueue(OP_ADD, 100, 32'h0);
      enqueue(OP_ADD, 102, -32'sd3);
      enqueue(OP_ADD, 101, 32'h0);
      // negative slope, span of two: quotient must round toward zero
      enqueue(OP_QUERY, 101, 32'h0);
      enqueue(OP_QUERY, 50, 32'h0);
      enqueue(OP_QUERY, 200, 32'h0);
      enqueue(OP_QUERY, 102, 32'h0);
      enqueue(OP_UNUSED, -65536, 32'hFFFF_FFFF);
      enqueue(OP_CLEAR, POS_MAX, 32'hFFFF_FFFF);
   endtask

   // Main sequence: reset, directed items, then four phases of varied sender idling and receiver stalls
   initial begin
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      wait_drained();
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
            default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
         endcase
         queue_random(PHASE_ITEMS, phase == 0);
         // queue nothing more until every answer is back
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule
